// File: sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary min-heap queue
// Operation codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Parameter defaults
    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    // Operation codes carried on the opcode port
    typedef logic [0:0] t_opcode;
    localparam t_opcode OP_INSERT = 1'b0;
    localparam t_opcode OP_POP    = 1'b1;

    // Status codes returned with every result beat
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

// File: sv/binary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core: bounded binary min-heap of signed keys
// Insert sifts the new key up, pop moves the last key to the root and sifts
// it down. One shared comparator and one RAM read port do all the work.
// ----------------------------------------------------------------------------
// Sequence: insert sifts up from the new leaf with one RAM read per parent;
// pop reads the last key, then sifts it down with two RAM reads per pair of
// children. Refused ops and a pop that empties the heap go straight to the
// root read-back. busy is high from the accepted start until the result, so
// one op is handled at a time. Result strobed one cycle on o_valid, the
// receiver cannot stall. Sync active-low reset empties the heap.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core #(
    parameter int CAPACITY  = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bmhq_pkg::DEF_KEY_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bmhq_pkg::t_opcode                i_opcode,
    input  logic signed [31:0]               i_value,
    output logic                             o_valid,
    output logic signed [31:0]               o_top_value,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count,
    output logic                             o_empty_res,
    output bmhq_pkg::t_status                o_status
);

    import bmhq_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = (KEY_WIDTH > 32) ? KEY_WIDTH : 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN_RD,
        S_FIN
    } t_state;

    t_state                 r_state;
    logic [IW-1:0]          r_count;
    logic [IW-1:0]          r_id;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [KEY_WIDTH-1:0]   r_best;
    logic                   r_left_lt;
    t_status                r_status;
    logic                   r_valid;
    logic signed [31:0]     r_top_value;
    logic [IW-1:0]          r_out_count;
    logic                   r_empty_res;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [KEY_WIDTH-1:0]   ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [KEY_WIDTH-1:0]   ram_rdata;

    logic signed [EXT_W-1:0] in_ext;
    logic [KEY_WIDTH-1:0]    in_key;
    logic signed [EXT_W-1:0] top_ext;
    logic [IW-1:0]           id_m1;
    logic [IW-1:0]           parent;
    logic [IW-1:0]           parent_m1;
    logic [IW:0]             child;
    logic [IW:0]             child_m1;
    logic [IW:0]             count_x;
    logic                    no_child;
    logic [KEY_WIDTH-1:0]    cmp_a;
    logic [KEY_WIDTH-1:0]    cmp_b;
    logic                    cmp_lt;
    logic                    take_right;
    logic                    dn_move;
    logic [KEY_WIDTH-1:0]    best;
    logic [IW-1:0]           best_id;

    // Key capture: low KEY_WIDTH bits of the sign-extended input
    assign in_ext  = EXT_W'(i_value);
    assign in_key  = in_ext[KEY_WIDTH-1:0];
    assign top_ext = EXT_W'($signed(ram_rdata));

    // Index arithmetic on the one-based heap
    assign id_m1     = r_id - IW'(1);
    assign parent    = r_id >> 1;
    assign parent_m1 = parent - IW'(1);
    assign child     = {r_id, 1'b0};
    assign child_m1  = child - (IW+1)'(1);
    assign count_x   = {1'b0, r_count};
    assign no_child  = child > count_x;

    // Shared comparator operands: key vs parent, left vs key, right vs best so far
    always_comb begin
        cmp_a = r_key;
        cmp_b = ram_rdata;
        case (r_state)
            S_DN_RDR: begin
                cmp_a = ram_rdata;
                cmp_b = r_key;
            end
            S_DN_CMP: begin
                cmp_a = ram_rdata;
                cmp_b = r_best;
            end
            default: begin
                cmp_a = r_key;
                cmp_b = ram_rdata;
            end
        endcase
    end

    assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

    // Sift-down choice; ties keep the left child or the key
    assign take_right = (child < count_x) && cmp_lt;
    assign dn_move    = take_right || r_left_lt;
    assign best       = take_right ? ram_rdata : r_best;
    assign best_id    = take_right ? child[IW-1:0] + IW'(1) : child[IW-1:0];

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = id_m1[AW-1:0];
        ram_wdata = r_key;
        ram_raddr = '0;
        case (r_state)
            S_UP_RD: begin
                if (r_id == IW'(1)) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = parent_m1[AW-1:0];
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    ram_wdata = ram_rdata;
                end
            end
            S_POP_RD: begin
                // last entry sits at index count + 1 after the decrement
                ram_raddr = r_count[AW-1:0];
            end
            S_DN_RDL: begin
                if (no_child) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = child_m1[AW-1:0];
                end
            end
            S_DN_RDR: begin
                ram_raddr = child[AW-1:0];
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (dn_move) begin
                    ram_wdata = best;
                end
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // Sequencer and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key    <= in_key;
                        r_status <= ST_OK;
                        if (i_opcode == OP_INSERT) begin
                            if (r_count >= IW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_FIN_RD;
                            end else begin
                                r_count <= r_count + IW'(1);
                                r_id    <= r_count + IW'(1);
                                r_state <= S_UP_RD;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_FIN_RD;
                            end else begin
                                r_count <= r_count - IW'(1);
                                r_state <= (r_count == IW'(1)) ? S_FIN_RD : S_POP_RD;
                            end
                        end
                    end
                end
                S_UP_RD: begin
                    r_state <= (r_id == IW'(1)) ? S_FIN_RD : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (cmp_lt) begin
                        r_id    <= parent;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_LD;
                end
                S_POP_LD: begin
                    r_key   <= ram_rdata;
                    r_id    <= IW'(1);
                    r_state <= S_DN_RDL;
                end
                S_DN_RDL: begin
                    r_state <= no_child ? S_FIN_RD : S_DN_RDR;
                end
                S_DN_RDR: begin
                    // keep the smaller of left child and key
                    r_left_lt <= cmp_lt;
                    r_best    <= cmp_lt ? ram_rdata : r_key;
                    r_state   <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (dn_move) begin
                        r_id    <= best_id;
                        r_state <= S_DN_RDL;
                    end else begin
                        r_state <= S_FIN_RD;
                    end
                end
                S_FIN_RD: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // root read back; zero when empty
                    r_valid     <= 1'b1;
                    r_top_value <= (r_count != '0) ? top_ext[31:0] : '0;
                    r_out_count <= r_count;
                    r_empty_res <= (r_count == '0);
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    bmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_top_value = r_top_value;
    assign o_count     = r_out_count;
    assign o_empty_res = r_empty_res;
    assign o_status    = r_status;

endmodule

// File: sv/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: bench/binary_min_heap_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_tb: self-checking bench for the min-heap queue
// Drives insert and pop beats through the start/busy handshake and keeps a
// shadow heap that predicts the minimum, count, empty flag and status of every
// beat. Covers pops and inserts refused on an empty or full heap, equal keys,
// extreme keys, and random traffic with several sender idling mixes.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_tb;

    import bmhq_pkg::*;

    localparam int CAP      = DEF_CAPACITY;
    localparam int CNT_W    = $clog2(CAP + 1);
    localparam int PERIOD   = 10;
    localparam int DRAIN_CY = 60;

    // One predicted result beat
    typedef struct {
        logic signed [31:0] top;
        logic [CNT_W-1:0]   count;
        logic               empty;
        t_status            status;
    } t_heap_outcome;

    // Shadow heap plus the queue of predicted result beats
    class t_heap_tracker;
        logic signed [31:0] slots [1:CAP];
        int unsigned        n_keys;
        t_heap_outcome      pending_outcomes [$];
        int unsigned        fails;

        function new();
            n_keys = 0;
            fails  = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [31:0] t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        // Apply one accepted beat to the shadow heap, queue its result
        function void note_op(t_opcode op, logic signed [31:0] key);
            t_heap_outcome res;
            t_status       st;
            int unsigned   id;
            int unsigned   c;
            st = ST_OK;
            if (op == OP_INSERT) begin
                if (n_keys >= CAP) begin
                    st = ST_FULL;
                end else begin
                    n_keys++;
                    id        = n_keys;
                    slots[id] = key;
                    // sift up, no swap on equal keys
                    while (id > 1 && slots[id] < slots[id / 2]) begin
                        swap_slots(id, id / 2);
                        id = id / 2;
                    end
                end
            end else begin
                if (n_keys == 0) begin
                    st = ST_EMPTY;
                end else begin
                    n_keys--;
                    if (n_keys != 0) begin
                        slots[1] = slots[n_keys + 1];
                        id       = 1;
                        // sift down toward the smaller child
                        while (2 * id <= n_keys) begin
                            c = 2 * id;
                            if (c + 1 <= n_keys && slots[c + 1] < slots[c])
                                c++;
                            if (!(slots[c] < slots[id]))
                                break;
                            swap_slots(id, c);
                            id = c;
                        end
                    end
                end
            end
            res.top    = (n_keys > 0) ? slots[1] : '0;
            res.count  = n_keys[CNT_W-1:0];
            res.empty  = (n_keys == 0);
            res.status = st;
            pending_outcomes.insert(pending_outcomes.size(), res);
        endfunction

        // Compare one result beat with the oldest prediction
        function void check_outcome(logic signed [31:0] top, logic [CNT_W-1:0] cnt,
                                    logic emp, t_status st);
            t_heap_outcome w;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat top=%0d count=%0d empty=%0b status=%0d",
                         $time, top, cnt, emp, st);
                fails++;
                return;
            end
            w = pending_outcomes.pop_front();
            if (top !== w.top) begin
                $display("%0t: top_value expected %0d got %0d", $time, w.top, top);
                fails++;
            end
            if (cnt !== w.count) begin
                $display("%0t: count expected %0d got %0d", $time, w.count, cnt);
                fails++;
            end
            if (emp !== w.empty) begin
                $display("%0t: empty_res expected %0b got %0b", $time, w.empty, emp);
                fails++;
            end
            if (st !== w.status) begin
                $display("%0t: status expected %0d got %0d", $time, w.status, st);
                fails++;
            end
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    t_opcode                  i_opcode;
    logic signed [31:0]       i_value;
    logic                     o_valid;
    logic signed [31:0]       o_top_value;
    logic [CNT_W-1:0]         o_count;
    logic                     o_empty_res;
    t_status                  o_status;

    t_heap_tracker tracker = new();

    binary_min_heap_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_top_value (o_top_value),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

    // Clock
    initial i_clk = 1'b0;
    always #(PERIOD / 2) i_clk = ~i_clk;

    // Result monitor: beats are strobed for one cycle, no back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            tracker.check_outcome(o_top_value, o_count, o_empty_res, o_status);
    end

    // Key mix: full range, a narrow band for duplicates, extremes
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(9))
            5, 6, 7: return $signed($urandom_range(15)) - 8;
            8: begin
                case ($urandom_range(3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            9: return ($urandom_range(1)) ? 32'sh7fffffff - $urandom_range(3)
                                           : 32'sh80000000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Present one beat and hold it until accepted, then maybe go idle
    task automatic send_op(t_opcode op, logic signed [31:0] key, int idle_pct);
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_op(op, key);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(13, 45)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Random beats with a given insert share
    task automatic run_mix(int n_items, int ins_pct, int idle_pct);
        repeat (n_items)
            send_op(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_POP,
                    pick_key(), idle_pct);
    endtask

    // Stimulus
    initial begin
        start    = 1'b0;
        i_opcode = OP_INSERT;
        i_value  = '0;
        i_rst_n  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: pop on empty, extremes, equal keys, drain past empty
        send_op(OP_POP,    32'sd0,          0);
        send_op(OP_INSERT, 32'sd0,          0);
        send_op(OP_INSERT, 32'sh7fffffff,   0);
        send_op(OP_INSERT, 32'sh80000000,   0);
        send_op(OP_INSERT, 32'sh80000000,   0);
        send_op(OP_INSERT, -32'sd1,         0);
        send_op(OP_INSERT, 32'sd5,          0);
        send_op(OP_INSERT, 32'sd5,          0);
        send_op(OP_INSERT, 32'sh7fffffff,   0);
        repeat (9) send_op(OP_POP, $urandom, 0);
        send_op(OP_INSERT, 32'sh55555555,   0);
        send_op(OP_INSERT, 32'shaaaaaaaa,   0);
        send_op(OP_POP,    32'shffffffff,   0);
        send_op(OP_POP,    32'sh0,          0);

        // no idling, 60 percent inserts
        run_mix(200, 60, 0);

        // sender idle about half the time; fill to capacity, then hit it
        while (tracker.n_keys < CAP)
            send_op(($urandom_range(99) < 95) ? OP_INSERT : OP_POP, pick_key(), 47);
        repeat (12)
            send_op(($urandom_range(3) == 0) ? OP_POP : OP_INSERT, pick_key(), 47);

        // no idling, pop-heavy
        run_mix(150, 20, 0);

        // light idling, balanced
        run_mix(100, 50, 16);

        start <= 1'b0;

        // wait for every predicted beat, then let the pipe settle
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
        if (tracker.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
